@@ rtl/eauc_pkg.sv @@
// eauc_pkg: shared constants and types for the encoder ui control block
// no dependencies; used by the controller, datapath and top level
package eauc_pkg;

	// number of display modes the first switch cycles through
	localparam int NumModes = 4;
	localparam logic [4:0] ModeLast = 5'(NumModes - 1);

	// configuration port geometry
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_MIN_BRIGHT   = 3'd0,
		REG_MAX_BRIGHT   = 3'd1,
		REG_LIGHT_LOW    = 3'd2,
		REG_LIGHT_HIGH   = 3'd3,
		REG_START_BRIGHT = 3'd4,
		REG_START_HUE    = 3'd5,
		REG_START_MODE   = 3'd6,
		REG_START_TEXT   = 3'd7
	} cfg_reg_t;

	// reset values of configuration and state
	localparam logic [7:0]  MinBrightRst   = 8'd0;
	localparam logic [7:0]  MaxBrightRst   = 8'd255;
	localparam logic [11:0] LightLowRst    = 12'd500;
	localparam logic [11:0] LightHighRst   = 12'd1500;
	localparam logic [7:0]  StartBrightRst = 8'd128;
	localparam logic [15:0] StartHueRst    = 16'd0;
	localparam logic [1:0]  StartModeRst   = 2'd0;
	localparam logic        StartTextRst   = 1'b0;

	// commands from controller to datapath
	typedef struct packed {
		logic load;    // capture the accepted item
		logic mul;     // form both squares
		logic mac;     // form cube and brightness sum
		logic commit;  // update the state registers
	} eauc_cmd_t;

endpackage

@@ rtl/eauc_in_if.sv @@
// eauc_in_if: input channel carrying one poll tick item
// depends on nothing
interface eauc_in_if;
	logic              valid;
	logic              ready;
	logic              mode_press;
	logic              text_press;
	logic signed [5:0] bright_detents;
	logic signed [5:0] hue_detents;
	logic [11:0]       light_level;

	modport source (
		output valid, mode_press, text_press, bright_detents, hue_detents, light_level,
		input  ready
	);
	modport sink (
		input  valid, mode_press, text_press, bright_detents, hue_detents, light_level,
		output ready
	);
endinterface

@@ rtl/eauc_out_if.sv @@
// eauc_out_if: output channel carrying one updated ui state item
// depends on nothing
interface eauc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  brightness_out;
	logic [15:0] hue_out;
	logic [1:0]  display_mode_out;
	logic        text_mode_out;
	logic        panel_enable_out;

	modport source (
		output valid, brightness_out, hue_out, display_mode_out, text_mode_out,
		output panel_enable_out,
		input  ready
	);
	modport sink (
		input  valid, brightness_out, hue_out, display_mode_out, text_mode_out,
		input  panel_enable_out,
		output ready
	);
endinterface

@@ rtl/encoder_accel_ui_control.sv @@
// encoder_accel_ui_control: rotary encoder ui controller with light latch
// an accepted item steps through square, cube and sum, and commit before its result is valid
// the sequencer takes no new item until the current one has been committed
// a result not yet taken holds the commit step, and no new item is taken meanwhile
// reset: arst_n clears control, loads configuration defaults and start state, panel on
// depends on eauc_pkg, eauc_in_if, eauc_out_if, eauc_ctrl, eauc_dp
module encoder_accel_ui_control (
	input  logic                          clk,
	input  logic                          arst_n,
	eauc_in_if.sink                       in_ch,
	eauc_out_if.source                    out_ch,
	input  logic                          cfg_we,
	input  logic [eauc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [eauc_pkg::CfgDataW-1:0] cfg_data
);

	eauc_pkg::eauc_cmd_t cmd;

	// sequencer
	eauc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	// datapath
	eauc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mode_press       (in_ch.mode_press),
		.text_press       (in_ch.text_press),
		.bright_detents   (in_ch.bright_detents),
		.hue_detents      (in_ch.hue_detents),
		.light_level      (in_ch.light_level),
		.brightness_out   (out_ch.brightness_out),
		.hue_out          (out_ch.hue_out),
		.display_mode_out (out_ch.display_mode_out),
		.text_mode_out    (out_ch.text_mode_out),
		.panel_enable_out (out_ch.panel_enable_out)
	);

endmodule

@@ rtl/eauc_ctrl.sv @@
// eauc_ctrl: sequencer stepping one item through the datapath
// depends on eauc_pkg
module eauc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	output eauc_pkg::eauc_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_MAC,
		ST_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// command decode
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.mul    = (state_q == ST_MUL);
		cmd.mac    = (state_q == ST_MAC);
		cmd.commit = (state_q == ST_UPD) && out_free;
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// set on commit, cleared once the result is taken
			if ((state_q == ST_UPD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_MAC;
				ST_MAC: state_q <= ST_UPD;
				ST_UPD: begin
					// hold until the previous result has been taken
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/eauc_dp.sv @@
// eauc_dp: configuration registers, ui state and arithmetic datapath
// depends on eauc_pkg
module eauc_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  eauc_pkg::eauc_cmd_t                  cmd,
	input  logic                                 cfg_we,
	input  logic [eauc_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [eauc_pkg::CfgDataW-1:0]        cfg_data,
	input  logic                                 mode_press,
	input  logic                                 text_press,
	input  logic signed [5:0]                    bright_detents,
	input  logic signed [5:0]                    hue_detents,
	input  logic [11:0]                          light_level,
	output logic [7:0]                           brightness_out,
	output logic [15:0]                          hue_out,
	output logic [1:0]                           display_mode_out,
	output logic                                 text_mode_out,
	output logic                                 panel_enable_out
);

	// configuration
	logic [7:0]  min_bright_q, max_bright_q;
	logic [11:0] light_low_q, light_high_q;

	// ui state
	logic [7:0]  bright_q;
	logic [15:0] hue_q;
	logic [1:0]  mode_q;
	logic        text_q;
	logic        panel_q;

	// captured item
	logic        mode_press_q, text_press_q;
	logic        neg1_q, neg2_q;
	logic [4:0]  mag1_q, mag2_q;
	logic [11:0] light_q;

	// products, the cube kept modulo 8192 since only its low bits reach the hue
	logic [9:0]         sq1_q, sq2_q;
	logic [12:0]        cube_q;
	logic signed [11:0] bsum_q;

	// detent saturation and magnitude
	logic [4:0]  mag1_d, mag2_d;
	logic [5:0]  abs1, abs2;

	assign abs1   = bright_detents[5] ? 6'(-bright_detents) : bright_detents;
	assign abs2   = hue_detents[5] ? 6'(-hue_detents) : hue_detents;
	// a count of -32 saturates to -31
	assign mag1_d = abs1[5] ? 5'd31 : abs1[4:0];
	assign mag2_d = abs2[5] ? 5'd31 : abs2[4:0];

	// next-state logic
	logic signed [11:0] sq1_s;
	logic [7:0]         bright_d;
	logic [15:0]        cube8;
	logic [1:0]         mode_d;
	logic               panel_d;

	assign sq1_s = $signed({2'b00, sq1_q});
	assign cube8 = {cube_q, 3'b000};

	always_comb begin
		if (bsum_q < $signed({4'b0000, min_bright_q})) begin
			bright_d = min_bright_q;
		end else if (bsum_q > $signed({4'b0000, max_bright_q})) begin
			bright_d = max_bright_q;
		end else begin
			bright_d = bsum_q[7:0];
		end
	end

	always_comb begin
		mode_d = mode_q;
		if (mode_press_q) begin
			if ({3'b000, mode_q} >= eauc_pkg::ModeLast) begin
				mode_d = 2'd0;
			end else begin
				mode_d = mode_q + 2'd1;
			end
		end
	end

	// hysteresis latch, low threshold wins
	always_comb begin
		panel_d = panel_q;
		if (light_q < light_low_q) begin
			panel_d = 1'b0;
		end else if (light_q > light_high_q) begin
			panel_d = 1'b1;
		end
	end

	// item capture and product pipeline
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_press_q <= mode_press;
			text_press_q <= text_press;
			neg1_q       <= bright_detents[5];
			neg2_q       <= hue_detents[5];
			mag1_q       <= mag1_d;
			mag2_q       <= mag2_d;
			light_q      <= light_level;
		end
		if (cmd.mul) begin
			sq1_q <= mag1_q * mag1_q;
			sq2_q <= mag2_q * mag2_q;
		end
		if (cmd.mac) begin
			cube_q <= 13'(sq2_q * 13'(mag2_q));
			bsum_q <= neg1_q ? $signed({4'b0000, bright_q}) - sq1_s
			                 : $signed({4'b0000, bright_q}) + sq1_s;
		end
	end

	// configuration and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bright_q <= eauc_pkg::MinBrightRst;
			max_bright_q <= eauc_pkg::MaxBrightRst;
			light_low_q  <= eauc_pkg::LightLowRst;
			light_high_q <= eauc_pkg::LightHighRst;
			bright_q     <= eauc_pkg::StartBrightRst;
			hue_q        <= eauc_pkg::StartHueRst;
			mode_q       <= eauc_pkg::StartModeRst;
			text_q       <= eauc_pkg::StartTextRst;
			panel_q      <= 1'b1;
		end else begin
			if (cmd.commit) begin
				bright_q <= bright_d;
				hue_q    <= neg2_q ? hue_q - cube8 : hue_q + cube8;
				mode_q   <= mode_d;
				text_q   <= text_q ^ text_press_q;
				panel_q  <= panel_d;
			end
			if (cfg_we) begin
				case (eauc_pkg::cfg_reg_t'(cfg_index))
					eauc_pkg::REG_MIN_BRIGHT:   min_bright_q <= cfg_data[7:0];
					eauc_pkg::REG_MAX_BRIGHT:   max_bright_q <= cfg_data[7:0];
					eauc_pkg::REG_LIGHT_LOW:    light_low_q  <= cfg_data[11:0];
					eauc_pkg::REG_LIGHT_HIGH:   light_high_q <= cfg_data[11:0];
					eauc_pkg::REG_START_BRIGHT: bright_q     <= cfg_data[7:0];
					eauc_pkg::REG_START_HUE:    hue_q        <= cfg_data[15:0];
					eauc_pkg::REG_START_MODE:   mode_q       <= cfg_data[1:0];
					eauc_pkg::REG_START_TEXT:   text_q       <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	assign brightness_out   = bright_q;
	assign hue_out          = hue_q;
	assign display_mode_out = mode_q;
	assign text_mode_out    = text_q;
	assign panel_enable_out = panel_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking testbench for encoder_accel_ui_control, one file
// depends on eauc_pkg, eauc_in_if, eauc_out_if and the block itself
module tb;

	localparam int ResultLatency = 4;
	localparam int QuietLimit    = 4000;
	localparam int LongHold      = 400;

	// one poll tick and one ui state result
	typedef struct packed {
		logic              mode_press;
		logic              text_press;
		logic signed [5:0] bright_detents;
		logic signed [5:0] hue_detents;
		logic [11:0]       light_level;
	} tick_t;

	typedef struct packed {
		logic [7:0]  brightness;
		logic [15:0] hue;
		logic [1:0]  display_mode;
		logic        text_mode;
		logic        panel_enable;
	} ui_state_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [eauc_pkg::CfgIdxW-1:0]  cfg_index;
	logic [eauc_pkg::CfgDataW-1:0] cfg_data;

	eauc_in_if  in_ch ();
	eauc_out_if out_ch ();

	encoder_accel_ui_control dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of configuration and state
	logic [7:0]  cfg_min_bright, cfg_max_bright;
	logic [11:0] cfg_light_low, cfg_light_high;
	logic [7:0]  ui_bright;
	logic [15:0] ui_hue;
	logic [1:0]  ui_mode;
	logic        ui_text;
	logic        ui_panel;

	ui_state_t pending_ui_q[$];
	int        mismatch_count = 0;
	int        result_count   = 0;
	int        quiet_cycles   = 0;
	int        hold_cycles    = 0;
	bit        idle_on        = 1'b0;
	bit        stall_on       = 1'b0;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic note_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// state after reset
	task automatic load_reset_state();
		cfg_min_bright = eauc_pkg::MinBrightRst;
		cfg_max_bright = eauc_pkg::MaxBrightRst;
		cfg_light_low  = eauc_pkg::LightLowRst;
		cfg_light_high = eauc_pkg::LightHighRst;
		ui_bright      = eauc_pkg::StartBrightRst;
		ui_hue         = eauc_pkg::StartHueRst;
		ui_mode        = eauc_pkg::StartModeRst;
		ui_text        = eauc_pkg::StartTextRst;
		ui_panel       = 1'b1;
	endtask

	// advance the ui state by one tick and return the new state
	function automatic ui_state_t next_ui_state(input tick_t t);
		logic signed [5:0] d_bright, d_hue;
		int                sq, level, mag;
		logic [15:0]       cube8;
		ui_state_t         r;
		d_bright = (t.bright_detents == -6'sd32) ? -6'sd31 : t.bright_detents;
		d_hue    = (t.hue_detents == -6'sd32) ? -6'sd31 : t.hue_detents;

		// light hysteresis, low test first
		if (t.light_level < cfg_light_low)
			ui_panel = 1'b0;
		else if (t.light_level > cfg_light_high)
			ui_panel = 1'b1;

		if (t.mode_press) begin
			if (int'(ui_mode) >= eauc_pkg::NumModes - 1)
				ui_mode = 2'd0;
			else
				ui_mode = ui_mode + 2'd1;
		end
		if (t.text_press)
			ui_text = ~ui_text;

		// signed square then clamp, lower bound first
		sq    = int'(d_bright) * int'(d_bright);
		level = int'(ui_bright) + ((d_bright < 0) ? -sq : sq);
		if (level < int'(cfg_min_bright))
			level = int'(cfg_min_bright);
		else if (level > int'(cfg_max_bright))
			level = int'(cfg_max_bright);
		ui_bright = level[7:0];

		// eight times the signed cube, wrapping
		mag   = (d_hue < 0) ? -int'(d_hue) : int'(d_hue);
		cube8 = 16'(8 * mag * mag * mag);
		ui_hue = (d_hue < 0) ? ui_hue - cube8 : ui_hue + cube8;

		r.brightness   = ui_bright;
		r.hue          = ui_hue;
		r.display_mode = ui_mode;
		r.text_mode    = ui_text;
		r.panel_enable = ui_panel;
		return r;
	endfunction

	// register write, called at a falling edge, returns at a falling edge
	task automatic write_reg(input eauc_pkg::cfg_reg_t idx, input logic [15:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		case (idx)
			eauc_pkg::REG_MIN_BRIGHT:   cfg_min_bright = val[7:0];
			eauc_pkg::REG_MAX_BRIGHT:   cfg_max_bright = val[7:0];
			eauc_pkg::REG_LIGHT_LOW:    cfg_light_low  = val[11:0];
			eauc_pkg::REG_LIGHT_HIGH:   cfg_light_high = val[11:0];
			eauc_pkg::REG_START_BRIGHT: ui_bright      = val[7:0];
			eauc_pkg::REG_START_HUE:    ui_hue         = val;
			eauc_pkg::REG_START_MODE:   ui_mode        = val[1:0];
			eauc_pkg::REG_START_TEXT:   ui_text        = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// send one tick; returns at the rising edge where it was accepted
	task automatic send_tick(input tick_t t);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_ch.mode_press     = t.mode_press;
		in_ch.text_press     = t.text_press;
		in_ch.bright_detents = t.bright_detents;
		in_ch.hue_detents    = t.hue_detents;
		in_ch.light_level    = t.light_level;
		in_ch.valid          = 1'b1;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		pending_ui_q.push_back(next_ui_state(t));
	endtask

	// drop valid and wait until every result is back and the block is quiet
	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_ui_q.size() != 0)
			@(negedge clk);
		repeat (ResultLatency + 2) @(negedge clk);
	endtask

	function automatic tick_t make_tick(input logic mp, input logic tp,
			input logic signed [5:0] bd, input logic signed [5:0] hd, input logic [11:0] lv);
		tick_t t;
		t.mode_press     = mp;
		t.text_press     = tp;
		t.bright_detents = bd;
		t.hue_detents    = hd;
		t.light_level    = lv;
		return t;
	endfunction

	// random tick: detents mostly small or full range, light near a threshold or anywhere
	function automatic tick_t rand_tick();
		tick_t t;
		int    lv;
		t.mode_press = 1'($urandom_range(0, 1));
		t.text_press = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 1) == 0)
			t.bright_detents = 6'($urandom_range(0, 63));
		else
			t.bright_detents = 6'($urandom_range(0, 6) - 3);
		if ($urandom_range(0, 1) == 0)
			t.hue_detents = 6'($urandom_range(0, 63));
		else
			t.hue_detents = 6'($urandom_range(0, 6) - 3);
		case ($urandom_range(0, 3))
			0: lv = int'(cfg_light_low) + int'($urandom_range(0, 4)) - 2;
			1: lv = int'(cfg_light_high) + int'($urandom_range(0, 4)) - 2;
			default: lv = $urandom_range(0, 4095);
		endcase
		if (lv < 0)
			lv = 0;
		if (lv > 4095)
			lv = 4095;
		t.light_level = lv[11:0];
		return t;
	endfunction

	// write every register in one go
	task automatic load_setting(input logic [7:0] min_b, input logic [7:0] max_b,
			input logic [11:0] low, input logic [11:0] high, input logic [7:0] sb,
			input logic [15:0] sh, input logic [1:0] sm, input logic st);
		wait_drained();
		write_reg(eauc_pkg::REG_MIN_BRIGHT, 16'(min_b));
		write_reg(eauc_pkg::REG_MAX_BRIGHT, 16'(max_b));
		write_reg(eauc_pkg::REG_LIGHT_LOW, 16'(low));
		write_reg(eauc_pkg::REG_LIGHT_HIGH, 16'(high));
		write_reg(eauc_pkg::REG_START_BRIGHT, 16'(sb));
		write_reg(eauc_pkg::REG_START_HUE, sh);
		write_reg(eauc_pkg::REG_START_MODE, 16'(sm));
		write_reg(eauc_pkg::REG_START_TEXT, 16'(st));
	endtask

	// reset state, detent extremes, saturation, mode wrap, text toggle, light edges
	task automatic test_directed();
		send_tick(make_tick(1'b0, 1'b0, 6'sd0, 6'sd0, 12'd1000));
		send_tick(make_tick(1'b1, 1'b0, 6'sd31, 6'sd0, 12'd1000));
		send_tick(make_tick(1'b1, 1'b0, -6'sd31, 6'sd0, 12'd1000));
		send_tick(make_tick(1'b1, 1'b0, -6'sd32, 6'sd0, 12'd1000));
		send_tick(make_tick(1'b1, 1'b1, 6'sd5, 6'sd31, 12'd499));
		send_tick(make_tick(1'b0, 1'b1, -6'sd5, -6'sd31, 12'd500));
		send_tick(make_tick(1'b0, 1'b0, 6'sd0, -6'sd32, 12'd1500));
		send_tick(make_tick(1'b0, 1'b0, 6'sd1, 6'sd1, 12'd1501));
		send_tick(make_tick(1'b0, 1'b0, -6'sd1, -6'sd1, 12'd0));
		send_tick(make_tick(1'b0, 1'b0, 6'sd0, 6'sd0, 12'd4095));
		send_tick(make_tick(1'b1, 1'b1, 6'sd31, 6'sd31, 12'd4095));
		send_tick(make_tick(1'b1, 1'b1, -6'sd32, -6'sd32, 12'd0));
		send_tick(make_tick(1'b0, 1'b0, 6'sd3, 6'sd7, 12'd2048));
		send_tick(make_tick(1'b0, 1'b0, -6'sd3, -6'sd7, 12'd1234));
	endtask

	// several register settings including inverted clamps and overlapping thresholds
	task automatic test_settings();
		load_setting(8'd0, 8'd255, 12'd0, 12'd4095, 8'd0, 16'd0, 2'd0, 1'b0);
		repeat (40) send_tick(rand_tick());
		load_setting(8'd255, 8'd255, 12'd4095, 12'd4095, 8'd255, 16'hffff, 2'd3, 1'b1);
		repeat (40) send_tick(rand_tick());
		load_setting(8'd200, 8'd50, 12'd3000, 12'd1000, 8'd255, 16'hffff, 2'd3, 1'b1);
		repeat (40) send_tick(rand_tick());
		load_setting(8'd0, 8'd0, 12'd4095, 12'd0, 8'd0, 16'h0000, 2'd1, 1'b0);
		repeat (40) send_tick(rand_tick());
		load_setting(8'd16, 8'd240, 12'd1000, 12'd3000, 8'd100, 16'd12345, 2'd2, 1'b0);
		repeat (40) send_tick(rand_tick());
		repeat (3) begin
			load_setting(8'($urandom_range(0, 100)), 8'($urandom_range(100, 255)),
				12'($urandom_range(0, 2000)), 12'($urandom_range(1000, 4095)),
				8'($urandom), 16'($urandom), 2'($urandom), 1'($urandom));
			repeat (40) send_tick(rand_tick());
		end
	endtask

	// receiver holds off long while items keep coming, so the input stalls
	task automatic test_backpressure();
		bit keep_idle;
		keep_idle   = idle_on;
		idle_on     = 1'b0;
		hold_cycles = LongHold;
		repeat (40) send_tick(rand_tick());
		idle_on = keep_idle;
	endtask

	// sender pauses mid-stream until every result is back
	task automatic test_drain_pause();
		repeat (15) send_tick(rand_tick());
		wait_drained();
		repeat (15) send_tick(rand_tick());
	endtask

	task automatic test_random(input int count);
		repeat (count) send_tick(rand_tick());
	endtask

	// receiver ready with random stall bursts and a long hold on request
	initial begin
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				out_ch.ready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			out_ch.ready = 1'b1;
		end
	end

	// compare each result with the oldest expected state
	always @(posedge clk) begin : check_results
		ui_state_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			result_count++;
			if (pending_ui_q.size() == 0) begin
				note_mismatch($sformatf("result %0d arrived with nothing expected",
					result_count));
			end else begin
				want = pending_ui_q.pop_front();
				if (out_ch.brightness_out !== want.brightness)
					note_mismatch($sformatf("result %0d brightness got %0d want %0d",
						result_count, out_ch.brightness_out, want.brightness));
				if (out_ch.hue_out !== want.hue)
					note_mismatch($sformatf("result %0d hue got %0d want %0d",
						result_count, out_ch.hue_out, want.hue));
				if (out_ch.display_mode_out !== want.display_mode)
					note_mismatch($sformatf("result %0d display mode got %0d want %0d",
						result_count, out_ch.display_mode_out, want.display_mode));
				if (out_ch.text_mode_out !== want.text_mode)
					note_mismatch($sformatf("result %0d text mode got %0d want %0d",
						result_count, out_ch.text_mode_out, want.text_mode));
				if (out_ch.panel_enable_out !== want.panel_enable)
					note_mismatch($sformatf("result %0d panel enable got %0d want %0d",
						result_count, out_ch.panel_enable_out, want.panel_enable));
			end
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// main sequence
	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = eauc_pkg::REG_MIN_BRIGHT;
		cfg_data             = '0;
		in_ch.valid          = 1'b0;
		in_ch.mode_press     = 1'b0;
		in_ch.text_press     = 1'b0;
		in_ch.bright_detents = '0;
		in_ch.hue_detents    = '0;
		in_ch.light_level    = '0;
		load_reset_state();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		idle_on  = 1'b1;
		stall_on = 1'b1;
		test_directed();
		test_settings();
		test_backpressure();
		test_drain_pause();
		test_random(600);

		// closing stretch with no idling
		idle_on  = 1'b0;
		stall_on = 1'b0;
		test_random(150);

		wait_drained();
		repeat (ResultLatency * 4) @(negedge clk);
		if (mismatch_count == 0 && pending_ui_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
